// ===== sv/csrg_pkg.sv =====
package csrg_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_NNZ  = 4096;

    localparam int FUNC_W      = 2;
    localparam int TIDX_W      = 12;
    localparam int TDATA_W     = 64;
    localparam int EIDX_W      = 32;
    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int NNZ_AW      = $clog2(MAX_NNZ);
    localparam int ROW_END_W   = 13;
    localparam int COL_W       = 16;
    localparam int VALUE_W     = 64;
    localparam int CCOUNT_W    = 17;
    localparam int SKIP_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TUSER_W = 2;
    localparam int DIV_STEPS   = EIDX_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [FUNC_W-1:0] FUNC_WR_ROW_END = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_COLUMN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_VALUE   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RD_ELEMENT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SKIP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_PRECISION = 2'd2;

    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_OOR_BIT   = 1;

endpackage

// ===== sv/csr_sparse_dense_gather.sv =====
// Read transaction: accept, serial division, fetch of the row span, a scan of the
// row's column entries (check, then compare, per entry), then post the result.
// Write transactions complete on acceptance; a new transaction is taken only when idle.
// The result register lets the next transaction start while a result waits.
// rst_n clears control state and loads column_count 1, element_skip 0,
// double_precision 1; the three stores hold no reset value.
module csr_sparse_dense_gather (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // table_index[11:0], table_data[75:12], element_index[107:76], zero[111:108]
    input  logic [csrg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func[1:0]
    input  logic [csrg_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // element_value[63:0]
    output logic [csrg_pkg::VALUE_W-1:0]         m_axis_tdata,
    // found[0], out_of_range[1]
    output logic [csrg_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csrg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csrg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV      = 3'd1;
    localparam logic [2:0] ST_ROW_A    = 3'd2;
    localparam logic [2:0] ST_ROW_B    = 3'd3;
    localparam logic [2:0] ST_ROW_C    = 3'd4;
    localparam logic [2:0] ST_SCAN_CHK = 3'd5;
    localparam logic [2:0] ST_SCAN_CMP = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    localparam int ROW_HI_W = csrg_pkg::EIDX_W - csrg_pkg::ROW_AW;

    logic [csrg_pkg::ROW_END_W-1:0] row_end_mem [csrg_pkg::MAX_ROWS];
    logic [csrg_pkg::COL_W-1:0]     column_mem  [csrg_pkg::MAX_NNZ];
    logic [csrg_pkg::VALUE_W-1:0]   value_mem   [csrg_pkg::MAX_NNZ];

    logic [csrg_pkg::CCOUNT_W-1:0]  column_count_reg;
    logic [csrg_pkg::SKIP_W-1:0]    element_skip_reg;
    logic                           double_precision_reg;

    logic [2:0]                     state_reg, state_next;
    logic [csrg_pkg::CCOUNT_W-1:0]  div_reg, div_next;
    logic [csrg_pkg::CCOUNT_W-1:0]  rem_reg, rem_next;
    logic [csrg_pkg::EIDX_W-1:0]    quo_reg, quo_next;
    logic [csrg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [csrg_pkg::ROW_END_W-1:0] start_reg, start_next;
    logic [csrg_pkg::ROW_END_W-1:0] end_reg, end_next;
    logic [csrg_pkg::ROW_END_W-1:0] pos_reg, pos_next;
    logic [csrg_pkg::VALUE_W-1:0]   res_value_reg, res_value_next;
    logic                           res_found_reg, res_found_next;
    logic                           res_oor_reg, res_oor_next;
    logic                           out_valid_reg, out_valid_next;
    logic [csrg_pkg::VALUE_W-1:0]   out_data_reg, out_data_next;
    logic [csrg_pkg::OUT_TUSER_W-1:0] out_user_reg, out_user_next;

    logic [csrg_pkg::ROW_END_W-1:0] row_rd_reg;
    logic [csrg_pkg::COL_W-1:0]     col_rd_reg;
    logic [csrg_pkg::VALUE_W-1:0]   val_rd_reg;

    logic                           s_fire;
    logic [csrg_pkg::TIDX_W-1:0]    in_table_index;
    logic [csrg_pkg::TDATA_W-1:0]   in_table_data;
    logic [csrg_pkg::EIDX_W-1:0]    in_element_index;
    logic [csrg_pkg::EIDX_W-1:0]    pos_sum;
    logic                           row_we, nnz_we;
    logic [csrg_pkg::ROW_AW-1:0]    row_rd_addr;
    logic [csrg_pkg::CCOUNT_W:0]    trial;
    logic [csrg_pkg::CCOUNT_W:0]    diff;
    logic                           out_free;

    assign in_table_index   = s_axis_tdata[csrg_pkg::TIDX_W-1:0];
    assign in_table_data    = s_axis_tdata[csrg_pkg::TIDX_W +: csrg_pkg::TDATA_W];
    assign in_element_index =
        s_axis_tdata[csrg_pkg::TIDX_W + csrg_pkg::TDATA_W +: csrg_pkg::EIDX_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign pos_sum = in_element_index + element_skip_reg;

    assign row_we = s_fire && (s_axis_tuser == csrg_pkg::FUNC_WR_ROW_END)
        && ({1'b0, in_table_index} < (csrg_pkg::TIDX_W + 1)'(csrg_pkg::MAX_ROWS));
    assign nnz_we = ({1'b0, in_table_index} < (csrg_pkg::TIDX_W + 1)'(csrg_pkg::MAX_NNZ));

    assign row_rd_addr = (state_reg == ST_ROW_A)
        ? quo_reg[csrg_pkg::ROW_AW-1:0] - csrg_pkg::ROW_AW'(1)
        : quo_reg[csrg_pkg::ROW_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_end_mem[in_table_index[csrg_pkg::ROW_AW-1:0]] <=
                in_table_data[csrg_pkg::ROW_END_W-1:0];
        end
        row_rd_reg <= row_end_mem[row_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && (s_axis_tuser == csrg_pkg::FUNC_WR_COLUMN) && nnz_we)
        begin
            column_mem[in_table_index[csrg_pkg::NNZ_AW-1:0]] <=
                in_table_data[csrg_pkg::COL_W-1:0];
        end
        col_rd_reg <= column_mem[pos_reg[csrg_pkg::NNZ_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && (s_axis_tuser == csrg_pkg::FUNC_WR_VALUE) && nnz_we)
        begin
            value_mem[in_table_index[csrg_pkg::NNZ_AW-1:0]] <= in_table_data;
        end
        val_rd_reg <= value_mem[pos_reg[csrg_pkg::NNZ_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg     <= csrg_pkg::CCOUNT_W'(1);
            element_skip_reg     <= '0;
            double_precision_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csrg_pkg::CFG_COLUMN_COUNT:
                    column_count_reg <= cfg_data[csrg_pkg::CCOUNT_W-1:0];
                csrg_pkg::CFG_ELEMENT_SKIP:
                    element_skip_reg <= cfg_data[csrg_pkg::SKIP_W-1:0];
                csrg_pkg::CFG_DOUBLE_PRECISION:
                    double_precision_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        res_oor_next   = res_oor_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        trial = {rem_reg, quo_reg[csrg_pkg::EIDX_W-1]};
        diff  = trial - {1'b0, div_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_axis_tuser == csrg_pkg::FUNC_RD_ELEMENT))
                begin
                    div_next = (column_count_reg == '0)
                        ? csrg_pkg::CCOUNT_W'(1) : column_count_reg;
                    rem_next       = '0;
                    quo_next       = pos_sum;
                    cnt_next       = '0;
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    res_oor_next   = 1'b0;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = diff[csrg_pkg::CCOUNT_W-1:0];
                    quo_next = {quo_reg[csrg_pkg::EIDX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[csrg_pkg::CCOUNT_W-1:0];
                    quo_next = {quo_reg[csrg_pkg::EIDX_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + csrg_pkg::DIV_CNT_W'(1);
                if (cnt_reg == csrg_pkg::DIV_CNT_W'(csrg_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_ROW_A;
                end
            end
            ST_ROW_A:
            begin
                if (quo_reg[csrg_pkg::EIDX_W-1:csrg_pkg::ROW_AW] != ROW_HI_W'(0))
                begin
                    res_oor_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_ROW_B;
                end
            end
            ST_ROW_B:
            begin
                start_next = (quo_reg[csrg_pkg::ROW_AW-1:0] == '0) ? '0 : row_rd_reg;
                state_next = ST_ROW_C;
            end
            ST_ROW_C:
            begin
                end_next   = row_rd_reg;
                pos_next   = start_reg;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (pos_reg >= end_reg)
                begin
                    state_next = ST_DONE;
                end
                else if ({1'b0, pos_reg} >= (csrg_pkg::ROW_END_W + 1)'(csrg_pkg::MAX_NNZ))
                begin
                    res_oor_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if ({1'b0, col_rd_reg} == rem_reg)
                begin
                    res_found_next = 1'b1;
                    res_value_next = double_precision_reg
                        ? val_rd_reg : {32'd0, val_rd_reg[31:0]};
                    state_next     = ST_DONE;
                end
                else
                begin
                    pos_next   = pos_reg + csrg_pkg::ROW_END_W'(1);
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_value_reg;
                    out_user_next[csrg_pkg::OUT_FOUND_BIT] = res_found_reg;
                    out_user_next[csrg_pkg::OUT_OOR_BIT]   = res_oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        pos_reg       <= pos_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_oor_reg   <= res_oor_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

endmodule

// ===== sv/csrg_checker.sv =====
module csrg_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [csrg_pkg::FUNC_W-1:0]          s_axis_tuser,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [csrg_pkg::VALUE_W-1:0]         m_axis_tdata,
    input  logic [csrg_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[csrg_pkg::OUT_FOUND_BIT] |-> m_axis_tdata == '0)
        else $error("nonzero value without a match");

    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[csrg_pkg::OUT_FOUND_BIT]
            && m_axis_tuser[csrg_pkg::OUT_OOR_BIT]))
        else $error("found and out_of_range both set");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == csrg_pkg::FUNC_RD_ELEMENT)
        |=> !s_axis_tready)
        else $error("input ready right after a read transaction");

endmodule

bind csr_sparse_dense_gather csrg_checker u_csrg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
